// ===== hw/rtl/fpmc_pkg.sv =====
// Shared types and constants for the fan, pump and mode controller.
package fpmc_pkg;

  localparam int unsigned TEMP_W  = 12;
  localparam int unsigned THYST_W = 9;
  localparam int unsigned SOIL_W  = 7;
  localparam int unsigned DUTY_W  = 8;
  localparam int unsigned FLAG_W  = 8;
  localparam int unsigned VALUE_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 12;

  localparam logic [DUTY_W-1:0] DUTY_MAX = 8'd255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_TRIP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TEMP_HYSTERESIS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_TRIP        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SOIL_HYSTERESIS  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FAN_DEFAULT_DUTY = 3'd4;

  // Configuration reset values
  localparam logic [TEMP_W-1:0]  RST_TEMP_TRIP        = 12'd300;
  localparam logic [THYST_W-1:0] RST_TEMP_HYSTERESIS  = 9'd20;
  localparam logic [SOIL_W-1:0]  RST_SOIL_TRIP        = 7'd40;
  localparam logic [SOIL_W-1:0]  RST_SOIL_HYSTERESIS  = 7'd10;
  localparam logic [DUTY_W-1:0]  RST_FAN_DEFAULT_DUTY = 8'd200;

  localparam logic [FLAG_W-1:0] FLAG_SET = 8'd1;
  localparam logic [FLAG_W-1:0] FLAG_CLR = 8'd0;
  localparam logic [VALUE_W-1:0] VALUE_ON = 16'd1;

  localparam logic KIND_COMMAND = 1'b0;
  localparam logic KIND_TICK    = 1'b1;

  typedef enum logic [1:0] {
    MODE_HAND  = 2'd0,
    MODE_HYST  = 2'd1,
    MODE_GATED = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    TOPIC_MODE      = 3'd0,
    TOPIC_HOME      = 3'd1,
    TOPIC_RAIN      = 3'd2,
    TOPIC_LAMP      = 3'd3,
    TOPIC_PUMP      = 3'd4,
    TOPIC_FAN       = 3'd5,
    TOPIC_FAN_SPEED = 3'd6,
    TOPIC_UNKNOWN   = 3'd7
  } topic_t;

  typedef struct packed {
    logic                kind;
    logic [2:0]          topic;
    logic [VALUE_W-1:0]  value;
    logic [TEMP_W-1:0]   temperature;
    logic [SOIL_W-1:0]   soil_percent;
  } item_t;

  typedef struct packed {
    logic [TEMP_W-1:0]  temp_trip;
    logic [THYST_W-1:0] temp_hysteresis;
    logic [SOIL_W-1:0]  soil_trip;
    logic [SOIL_W-1:0]  soil_hysteresis;
    logic [DUTY_W-1:0]  fan_default_duty;
  } cfg_t;

  typedef struct packed {
    logic              lamp_on;
    logic              pump_on;
    logic              fan_on;
    logic [DUTY_W-1:0] fan_duty;
    logic [1:0]        mode_now;
  } result_t;

endpackage

// ===== hw/rtl/fpmc_cfg_regs.sv =====
// Configuration register file with a plain write port.
module fpmc_cfg_regs
  import fpmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.temp_trip        <= RST_TEMP_TRIP;
      cfg.temp_hysteresis  <= RST_TEMP_HYSTERESIS;
      cfg.soil_trip        <= RST_SOIL_TRIP;
      cfg.soil_hysteresis  <= RST_SOIL_HYSTERESIS;
      cfg.fan_default_duty <= RST_FAN_DEFAULT_DUTY;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_TEMP_TRIP:        cfg.temp_trip        <= cfg_data[TEMP_W-1:0];
        CFG_TEMP_HYSTERESIS:  cfg.temp_hysteresis  <= cfg_data[THYST_W-1:0];
        CFG_SOIL_TRIP:        cfg.soil_trip        <= cfg_data[SOIL_W-1:0];
        CFG_SOIL_HYSTERESIS:  cfg.soil_hysteresis  <= cfg_data[SOIL_W-1:0];
        CFG_FAN_DEFAULT_DUTY: cfg.fan_default_duty <= cfg_data[DUTY_W-1:0];
        default: ;
      endcase
    end
  end

endmodule

// ===== hw/rtl/fpmc_ctrl_core.sv =====
// Controller state registers and the per-transaction update logic.
module fpmc_ctrl_core
  import fpmc_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    advance,
  input  item_t   item,
  input  cfg_t    cfg,
  output result_t result
);

  logic [1:0]        mode_reg, mode_reg_next;
  logic [FLAG_W-1:0] home_flag, home_flag_next;
  logic [FLAG_W-1:0] rain_flag, rain_flag_next;
  logic              lamp_reg, lamp_reg_next;
  logic              pump_reg, pump_reg_next;
  logic              fan_enable, fan_enable_next;
  logic [DUTY_W-1:0] remembered_speed, remembered_speed_next;
  logic [DUTY_W-1:0] applied_duty, applied_duty_next;

  logic              is_on;
  logic              mode_ok;
  logic [DUTY_W-1:0] clamped;
  logic              temp_hot;
  logic              temp_cool;
  logic [TEMP_W:0]   temp_low;
  logic              soil_dry;
  logic              soil_wet;
  logic [SOIL_W:0]   soil_high;
  logic              smart_fan;

  // Sensor compares, all exact integer arithmetic
  always_comb begin
    temp_low  = {cfg.temp_trip[TEMP_W-1], cfg.temp_trip}
              - {{(TEMP_W+1-THYST_W){1'b0}}, cfg.temp_hysteresis};
    temp_hot  = $signed(item.temperature) >= $signed(cfg.temp_trip);
    temp_cool = $signed({item.temperature[TEMP_W-1], item.temperature}) <= $signed(temp_low);
    soil_high = {1'b0, cfg.soil_trip} + {1'b0, cfg.soil_hysteresis};
    soil_dry  = item.soil_percent <= cfg.soil_trip;
    soil_wet  = {1'b0, item.soil_percent} >= soil_high;
    smart_fan = temp_hot && (home_flag == FLAG_SET);
    is_on     = item.value == VALUE_ON;
    // modes 0..2: non-negative, below 4, and not 3
    mode_ok   = (item.value[VALUE_W-1:2] == '0) && (item.value[1:0] != 2'd3);
    if (item.value[VALUE_W-1]) begin
      clamped = '0;
    end else if (item.value[VALUE_W-2:DUTY_W] != '0) begin
      clamped = DUTY_MAX;
    end else begin
      clamped = item.value[DUTY_W-1:0];
    end
  end

  always_comb begin
    mode_reg_next         = mode_reg;
    home_flag_next        = home_flag;
    rain_flag_next        = rain_flag;
    lamp_reg_next         = lamp_reg;
    pump_reg_next         = pump_reg;
    fan_enable_next       = fan_enable;
    remembered_speed_next = remembered_speed;
    applied_duty_next     = applied_duty;

    if (item.kind == KIND_COMMAND) begin
      case (topic_t'(item.topic))
        TOPIC_MODE: begin
          if (mode_ok) mode_reg_next = item.value[1:0];
        end
        TOPIC_HOME: home_flag_next = item.value[FLAG_W-1:0];
        TOPIC_RAIN: rain_flag_next = item.value[FLAG_W-1:0];
        TOPIC_LAMP: lamp_reg_next = is_on;
        TOPIC_PUMP: begin
          if (mode_reg == MODE_HAND) pump_reg_next = is_on;
        end
        TOPIC_FAN: begin
          if (mode_reg == MODE_HAND) begin
            fan_enable_next   = is_on;
            applied_duty_next = is_on ? remembered_speed : '0;
          end
        end
        TOPIC_FAN_SPEED: begin
          if (mode_reg == MODE_HAND) begin
            remembered_speed_next = clamped;
            if (fan_enable) applied_duty_next = clamped;
          end
        end
        default: ;
      endcase
    end else begin
      case (mode_reg)
        MODE_HYST: begin
          // hysteresis band: inside it the outputs hold
          if (temp_hot) begin
            fan_enable_next   = 1'b1;
            applied_duty_next = cfg.fan_default_duty;
          end else if (temp_cool) begin
            fan_enable_next   = 1'b0;
            applied_duty_next = '0;
          end
          if (soil_dry) begin
            pump_reg_next = 1'b1;
          end else if (soil_wet) begin
            pump_reg_next = 1'b0;
          end
        end
        MODE_GATED: begin
          fan_enable_next   = smart_fan;
          applied_duty_next = smart_fan ? cfg.fan_default_duty : '0;
          pump_reg_next     = soil_dry && (rain_flag == FLAG_CLR);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg         <= MODE_HAND;
      home_flag        <= FLAG_SET;
      rain_flag        <= FLAG_CLR;
      lamp_reg         <= 1'b0;
      pump_reg         <= 1'b0;
      fan_enable       <= 1'b0;
      remembered_speed <= RST_FAN_DEFAULT_DUTY;
      applied_duty     <= '0;
    end else if (advance) begin
      mode_reg         <= mode_reg_next;
      home_flag        <= home_flag_next;
      rain_flag        <= rain_flag_next;
      lamp_reg         <= lamp_reg_next;
      pump_reg         <= pump_reg_next;
      fan_enable       <= fan_enable_next;
      remembered_speed <= remembered_speed_next;
      applied_duty     <= applied_duty_next;
    end
  end

  assign result.lamp_on  = lamp_reg_next;
  assign result.pump_on  = pump_reg_next;
  assign result.fan_on   = fan_enable_next;
  assign result.fan_duty = applied_duty_next;
  assign result.mode_now = mode_reg_next;

endmodule

// ===== hw/rtl/fan_pump_mode_controller.sv =====
// Top level: input register, controller core, result register, config registers.
// An accepted transaction goes from the input register through the core to out_reg.
// Throughput: one transaction per cycle; while a result waits for out_ready one more
// transaction is taken into the input register, then in_ready drops until it moves on.
// Reset (rst, synchronous): pipeline empty, mode manual, lamp/pump/fan off, duty 0,
// home flag 1, rain flag 0, remembered speed 200, config registers at defaults.
module fan_pump_mode_controller
  import fpmc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  kind,
  input  logic [2:0]            topic,
  input  logic signed [15:0]    value,
  input  logic signed [11:0]    temperature,
  input  logic [6:0]            soil_percent,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  lamp_on,
  output logic                  pump_on,
  output logic                  fan_on,
  output logic [7:0]            fan_duty,
  output logic [1:0]            mode_now,
  input  logic                  cfg_write_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  item_t   in_reg;
  logic    in_reg_valid;
  result_t core_result;
  result_t out_reg;
  cfg_t    cfg;
  logic    advance;

  assign advance  = in_reg_valid && (!out_valid || out_ready);
  assign in_ready = !in_reg_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_reg.kind         <= kind;
      in_reg.topic        <= topic;
      in_reg.value        <= value;
      in_reg.temperature  <= temperature;
      in_reg.soil_percent <= soil_percent;
    end
  end

  fpmc_cfg_regs u_cfg (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .cfg          (cfg)
  );

  fpmc_ctrl_core u_core (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (in_reg),
    .cfg     (cfg),
    .result  (core_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_reg <= core_result;
  end

  assign lamp_on  = out_reg.lamp_on;
  assign pump_on  = out_reg.pump_on;
  assign fan_on   = out_reg.fan_on;
  assign fan_duty = out_reg.fan_duty;
  assign mode_now = out_reg.mode_now;

endmodule

// ===== hw/rtl/fpmc_checker.sv =====
// Port-level checker for the controller and its bind to the top level.
module fpmc_checker
  import fpmc_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       lamp_on,
  input logic       pump_on,
  input logic       fan_on,
  input logic [7:0] fan_duty,
  input logic [1:0] mode_now
);

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(lamp_on) && $stable(pump_on)
      && $stable(fan_on) && $stable(fan_duty) && $stable(mode_now))
    else $error("result changed while stalled");

  // Reset empties the result register.
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  // Duty is zero whenever a valid result has the fan off.
  a_duty_off: assert property (@(posedge clk) disable iff (rst)
    out_valid && !fan_on |-> fan_duty == '0)
    else $error("nonzero duty with fan off");

  // Mode reports only manual, auto or smart.
  a_mode_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> mode_now == MODE_HAND || mode_now == MODE_HYST
      || mode_now == MODE_GATED)
    else $error("mode code out of range");

endmodule

bind fan_pump_mode_controller fpmc_checker u_fpmc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .lamp_on   (lamp_on),
  .pump_on   (pump_on),
  .fan_on    (fan_on),
  .fan_duty  (fan_duty),
  .mode_now  (mode_now)
);
